FILE: src/mprq_pkg.sv
// ----------------------------------------------------------------------------
// mprq_pkg
// shared types and constants of the ready queue scheduler
// ----------------------------------------------------------------------------
package mprq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int ID_BITS_DEF     = 8;
    localparam int KEY_BITS_DEF    = 32;

    localparam int CMD_W    = 1;
    localparam int TID_W    = 8;
    localparam int RT_W     = 32;
    localparam int STATUS_W = 2;
    localparam int GID_W    = 8;
    localparam int LIMIT_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_PUT = 1'b0;
    localparam logic [CMD_W-1:0] CMD_GET = 1'b1;

    localparam logic [STATUS_W-1:0] ST_PUT_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GRANT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_LCFS = 2'd1;
    localparam logic [1:0] POL_SJF  = 2'd2;
    localparam logic [1:0] POL_RR   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_GRANT,
        S_OUT
    } state_t;

endpackage

FILE: src/mprq_if.sv
// ----------------------------------------------------------------------------
// mprq_req_if / mprq_rsp_if
// valid/ready channels of the ready queue scheduler
// ----------------------------------------------------------------------------
interface mprq_req_if;
    logic        valid;
    logic        ready;
    logic [0:0]  cmd;
    logic [7:0]  task_id;
    logic [31:0] remaining_time;

    modport source (output valid, output cmd, output task_id, output remaining_time,
                    input ready);
    modport sink   (input valid, input cmd, input task_id, input remaining_time,
                    output ready);
endinterface

interface mprq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  granted_id;
    logic [15:0] run_limit;

    modport source (output valid, output status, output granted_id, output run_limit,
                    input ready);
    modport sink   (input valid, input status, input granted_id, input run_limit,
                    output ready);
endinterface

FILE: src/multi_policy_ready_queue.sv
// ----------------------------------------------------------------------------
// multi_policy_ready_queue
// ready queue with fifo, stack, shortest-first and round robin policies
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  req     | in  | cmd, task_id, remaining_time
//  rsp     | out | status, granted_id, run_limit
//  cfg     | in  | cfg_we, cfg_idx, cfg_wdata
//
// one entry store in a synchronous memory, one read per cycle.
// fifo/stack put writes in idle, then gives the output beat; get reads in idle,
// takes the entry in the grant state, then gives the output beat. sorted put scans
// to the first larger key, shifts the tail down and writes in grant, or appends at the tail.
// reset clears head, count, policy and quantum; no clearing pass.
// a result waiting in the output register blocks the next request.
// ----------------------------------------------------------------------------
module multi_policy_ready_queue
#(
    parameter int QUEUE_DEPTH = mprq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = mprq_pkg::ID_BITS_DEF,
    parameter int KEY_BITS    = mprq_pkg::KEY_BITS_DEF
)(
    input  logic                            clk,
    input  logic                            rst_n,
    mprq_req_if.sink                        req,
    mprq_rsp_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [mprq_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [mprq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import mprq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = ID_BITS + KEY_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic [EW-1:0] mem [QUEUE_DEPTH];

    state_t state_reg, state_next;
    logic [1:0]          policy_reg;
    logic [LIMIT_W-1:0]  quantum_reg;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic [ID_BITS-1:0]  nid_reg, nid_next;
    logic [KEY_BITS-1:0] nkey_reg, nkey_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [GID_W-1:0]    gid_reg, gid_next;
    logic [LIMIT_W-1:0]  lim_reg, lim_next;

    logic          rd_en, wr_en;
    logic [CW-1:0] rd_off, wr_off;
    logic [EW-1:0] wr_data, rd_data;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] o);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(o);
        if (s >= (CW+1)'(QUEUE_DEPTH))
            s = s - (CW+1)'(QUEUE_DEPTH);
        return s[AW-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[slot(head_reg, wr_off)] <= wr_data;
        if (rd_en)
            rd_data <= mem[slot(head_reg, rd_off)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            policy_reg  <= POL_FCFS;
            quantum_reg <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cfg_we && cfg_idx == REG_POLICY)
                policy_reg <= cfg_wdata[1:0];
            if (cfg_we && cfg_idx == REG_QUANTUM)
                quantum_reg <= cfg_wdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        pos_reg  <= pos_next;
        nid_reg  <= nid_next;
        nkey_reg <= nkey_next;
        st_reg   <= st_next;
        gid_reg  <= gid_next;
        lim_reg  <= lim_next;
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        k_next     = k_reg;
        pos_next   = pos_reg;
        nid_next   = nid_reg;
        nkey_next  = nkey_reg;
        st_next    = st_reg;
        gid_next   = gid_reg;
        lim_next   = lim_reg;
        rd_en      = 1'b0;
        rd_off     = k_reg;
        wr_en      = 1'b0;
        wr_off     = k_reg;
        wr_data    = {nid_reg, nkey_reg};
        req.ready  = 1'b0;
        rsp.valid  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    nid_next  = ID_BITS'(req.task_id);
                    nkey_next = KEY_BITS'(req.remaining_time);
                    gid_next  = '0;
                    lim_next  = '0;
                    if (req.cmd == CMD_PUT)
                    begin
                        if (count_reg >= DEPTH_C)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_OUT;
                        end
                        else if (policy_reg == POL_SJF && count_reg != '0)
                        begin
                            // read head entry, scan begins
                            k_next     = '0;
                            rd_en      = 1'b1;
                            rd_off     = '0;
                            st_next    = ST_PUT_OK;
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_off     = count_reg;
                            wr_data    = {ID_BITS'(req.task_id),
                                          KEY_BITS'(req.remaining_time)};
                            count_next = count_reg + 1'b1;
                            st_next    = ST_PUT_OK;
                            state_next = S_OUT;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            st_next    = ST_EMPTY;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_off     = (policy_reg == POL_LCFS) ? count_reg - 1'b1 : '0;
                            st_next    = ST_GRANT;
                            state_next = S_GRANT;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                // rd_data holds entry k
                if (rd_data[KEY_BITS-1:0] <= nkey_reg)
                begin
                    k_next = k_reg + 1'b1;
                    if (k_reg + 1'b1 == count_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_off     = count_reg;
                        count_next = count_reg + 1'b1;
                        st_next    = ST_PUT_OK;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        rd_en  = 1'b1;
                        rd_off = k_reg + 1'b1;
                    end
                end
                else
                begin
                    // insertion point found, shift from tail down
                    k_next     = count_reg;
                    nid_next   = nid_reg;
                    rd_en      = 1'b1;
                    rd_off     = count_reg - 1'b1;
                    state_next = S_SHIFT;
                    pos_next   = k_reg;
                end
            end
            S_SHIFT:
            begin
                // rd_data holds entry k-1, move it to k
                wr_en  = 1'b1;
                wr_off = k_reg;
                wr_data = rd_data;
                k_next = k_reg - 1'b1;
                if (k_reg - 1'b1 == pos_reg)
                    state_next = S_GRANT;
                else
                begin
                    rd_en  = 1'b1;
                    rd_off = k_reg - 2'd2;
                end
            end
            S_GRANT:
            begin
                if (st_reg == ST_GRANT)
                begin
                    gid_next   = GID_W'(rd_data[EW-1:KEY_BITS]);
                    lim_next   = (policy_reg == POL_RR) ? quantum_reg : '0;
                    count_next = count_reg - 1'b1;
                    if (policy_reg != POL_LCFS)
                        head_next = slot(head_reg, CW'(1));
                end
                else
                begin
                    // finish sorted insert at position k
                    wr_en      = 1'b1;
                    wr_off     = k_reg;
                    count_next = count_reg + 1'b1;
                    st_next    = ST_PUT_OK;
                    gid_next   = '0;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                rsp.valid = 1'b1;
                if (rsp.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign rsp.status     = st_reg;
    assign rsp.granted_id = gid_reg;
    assign rsp.run_limit  = lim_reg;

endmodule

FILE: sim/mprq_tb_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mprq testbench channel notes
// the block's own interfaces are used for both channels; this file only
// holds the beat records the testbench keeps in its queues
// ----------------------------------------------------------------------------
package mprq_tb_pkg;
    import mprq_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [TID_W-1:0] task_id;
        logic [RT_W-1:0]  remaining_time;
    } sched_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GID_W-1:0]    granted_id;
        logic [LIMIT_W-1:0]  run_limit;
    } sched_rsp_t;
endpackage

FILE: sim/multi_policy_ready_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_policy_ready_queue_tb
// drives put/get beats under all four policies and checks every response
// against a behavioral queue model, with random source gaps and sink stalls
// ----------------------------------------------------------------------------
module multi_policy_ready_queue_tb;
    import mprq_pkg::*;
    import mprq_tb_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int WDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic req_fire;

    mprq_req_if req ();
    mprq_rsp_if rsp ();

    multi_policy_ready_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    // scheduler model state
    logic [1:0]          mdl_policy;
    logic [15:0]         mdl_quantum;
    logic [GID_W-1:0]    mdl_id [DEPTH];
    logic [RT_W-1:0]     mdl_key [DEPTH];
    int                  mdl_head;
    int                  mdl_fill;

    sched_req_t pending_beats[$];
    sched_rsp_t expected_rsp[$];

    int src_idle_pct;
    int snk_stall_pct;
    int errors;
    int wdog;
    int n_sent;
    int n_checked;
    int n_grant;
    int n_full;
    int n_empty;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic sched_rsp_t schedule_beat(sched_req_t b);
        sched_rsp_t r;
        int k;
        int i;
        r = '0;
        if (b.cmd == CMD_PUT)
        begin
            if (mdl_fill >= DEPTH)
                r.status = ST_FULL;
            else
            begin
                k = mdl_fill;
                if (mdl_policy == POL_SJF)
                begin
                    k = 0;
                    while (k < mdl_fill && mdl_key[(mdl_head + k) % DEPTH] <= b.remaining_time)
                        k++;
                    for (i = mdl_fill; i > k; i--)
                    begin
                        mdl_id[(mdl_head + i) % DEPTH] = mdl_id[(mdl_head + i - 1) % DEPTH];
                        mdl_key[(mdl_head + i) % DEPTH] = mdl_key[(mdl_head + i - 1) % DEPTH];
                    end
                end
                mdl_id[(mdl_head + k) % DEPTH] = b.task_id;
                mdl_key[(mdl_head + k) % DEPTH] = b.remaining_time;
                mdl_fill++;
                r.status = ST_PUT_OK;
            end
        end
        else if (mdl_fill == 0)
            r.status = ST_EMPTY;
        else
        begin
            if (mdl_policy == POL_LCFS)
                r.granted_id = mdl_id[(mdl_head + mdl_fill - 1) % DEPTH];
            else
            begin
                r.granted_id = mdl_id[mdl_head];
                mdl_head = (mdl_head + 1) % DEPTH;
            end
            mdl_fill--;
            if (mdl_policy == POL_RR)
                r.run_limit = mdl_quantum;
            r.status = ST_GRANT;
        end
        return r;
    endfunction

    // driver: one beat per handshake, new beat loaded at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_fire)
                pending_beats.delete(0);
            // an offered beat stays until it is taken
            if (!(req.valid && !req_fire))
            begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    req.valid <= 1'b1;
                    req.cmd <= pending_beats[0].cmd;
                    req.task_id <= pending_beats[0].task_id;
                    req.remaining_time <= pending_beats[0].remaining_time;
                end
                else
                    req.valid <= 1'b0;
            end
            rsp.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // monitor: predict on accepted requests, check accepted responses
    always @(posedge clk)
    begin
        sched_req_t b;
        sched_rsp_t got;
        sched_rsp_t exp_r;
        sched_rsp_t pred;
        if (rst_n)
        begin
            req_fire <= req.valid && req.ready;
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                wdog <= 0;
            else
                wdog <= wdog + 1;
            if (req.valid && req.ready)
            begin
                b = {req.cmd, req.task_id, req.remaining_time};
                pred = schedule_beat(b);
                expected_rsp = {expected_rsp, pred};
                n_sent <= n_sent + 1;
            end
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.status, rsp.granted_id, rsp.run_limit};
                if (expected_rsp.size() == 0)
                begin
                    $display("%0t: unexpected response %h", $time, got);
                    errors = errors + 1;
                end
                else
                begin
                    exp_r = expected_rsp[0];
                    expected_rsp.delete(0);
                    n_checked <= n_checked + 1;
                    if (exp_r.status == ST_GRANT) n_grant <= n_grant + 1;
                    if (exp_r.status == ST_FULL) n_full <= n_full + 1;
                    if (exp_r.status == ST_EMPTY) n_empty <= n_empty + 1;
                    if (got.status !== exp_r.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, got.status);
                        errors = errors + 1;
                    end
                    if (got.granted_id !== exp_r.granted_id)
                    begin
                        $display("%0t: granted_id expected %0d actual %0d",
                                 $time, exp_r.granted_id, got.granted_id);
                        errors = errors + 1;
                    end
                    if (got.run_limit !== exp_r.run_limit)
                    begin
                        $display("%0t: run_limit expected %0d actual %0d",
                                 $time, exp_r.run_limit, got.run_limit);
                        errors = errors + 1;
                    end
                end
            end
            if (wdog >= WDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("multi_policy_ready_queue verification failed");
                $finish;
            end
        end
        else
            req_fire <= 1'b0;
    end

    task automatic add_beat(logic [CMD_W-1:0] c, logic [7:0] id, logic [31:0] rt);
        sched_req_t b;
        b.cmd = c;
        b.task_id = id;
        b.remaining_time = rt;
        pending_beats = {pending_beats, b};
    endtask

    task automatic drain_all();
        while (pending_beats.size() > 0 || expected_rsp.size() > 0)
            @(posedge clk);
        // quiet gap before the next configuration write
        repeat (2 * DEPTH + 10) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_POLICY)
            mdl_policy = val[1:0];
        else
            mdl_quantum = val;
    endtask

    // random burst: puts and gets mixed by put_pct, keys biased to small and extreme values
    task automatic random_burst(int n, int put_pct);
        int j;
        logic [31:0] rt;
        for (j = 0; j < n; j++)
        begin
            case ($urandom_range(3))
                0: rt = $urandom_range(7);
                1: rt = $urandom_range(3) == 0 ? 32'hFFFF_FFFF : 32'd0;
                default: rt = $urandom;
            endcase
            add_beat(($urandom_range(99) < put_pct) ? CMD_PUT : CMD_GET,
                     $urandom_range(255), rt);
        end
    endtask

    initial
    begin
        int ph;
        int p;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.cmd = CMD_PUT;
        req.task_id = '0;
        req.remaining_time = '0;
        rsp.ready = 1'b0;
        mdl_policy = POL_FCFS;
        mdl_quantum = '0;
        mdl_head = 0;
        mdl_fill = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        errors = 0;
        wdog = 0;
        n_sent = 0;
        n_checked = 0;
        n_grant = 0;
        n_full = 0;
        n_empty = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty get, extremes, sorted ties, stack and round robin quanta
        add_beat(CMD_GET, 8'hFF, 32'hFFFF_FFFF);
        add_beat(CMD_PUT, 8'h00, 32'h0);
        add_beat(CMD_PUT, 8'hFF, 32'hFFFF_FFFF);
        add_beat(CMD_GET, 8'h00, 32'h0);
        add_beat(CMD_GET, 8'h00, 32'h0);
        add_beat(CMD_GET, 8'h00, 32'h0);
        drain_all();
        write_reg(REG_POLICY, {14'd0, POL_SJF});
        add_beat(CMD_PUT, 8'd1, 32'd5);
        add_beat(CMD_PUT, 8'd2, 32'd5);
        add_beat(CMD_PUT, 8'd3, 32'd1);
        add_beat(CMD_PUT, 8'd4, 32'hFFFF_FFFF);
        add_beat(CMD_PUT, 8'd5, 32'd0);
        drain_all();
        // policy change with entries queued
        write_reg(REG_POLICY, {14'd0, POL_LCFS});
        add_beat(CMD_GET, 8'd0, 32'd0);
        add_beat(CMD_PUT, 8'd6, 32'd2);
        add_beat(CMD_GET, 8'd0, 32'd0);
        drain_all();
        write_reg(REG_QUANTUM, 16'hFFFF);
        write_reg(REG_POLICY, {14'd0, POL_RR});
        add_beat(CMD_GET, 8'd0, 32'd0);
        add_beat(CMD_GET, 8'd0, 32'd0);
        drain_all();
        write_reg(REG_QUANTUM, 16'd0);
        add_beat(CMD_GET, 8'd0, 32'd0);
        add_beat(CMD_GET, 8'd0, 32'd0);
        drain_all();

        // random phases cycle through policies, quanta and idling patterns
        for (ph = 0; ph < 16; ph++)
        begin
            p = ph % 4;
            write_reg(REG_POLICY, {14'd0, 2'(p)});
            write_reg(REG_QUANTUM, (ph % 5 == 0) ? 16'hFFFF : 16'($urandom));
            case ((ph / 4) % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 55; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 55; end
                default: begin src_idle_pct = 9; snk_stall_pct = 9; end
            endcase
            // puts outweigh gets, so entries build up over the phases to hit full drops
            random_burst(60, 85);
            random_burst(30, 50);
            random_burst(12, 20);
            drain_all();
        end

        $display("summary: %0d request beats, %0d responses checked", n_sent, n_checked);
        $display("summary: %0d grants, %0d full drops, %0d empty gets over all four policies",
                 n_grant, n_full, n_empty);
        if (errors == 0)
            $display("multi_policy_ready_queue verification clean");
        else
            $display("multi_policy_ready_queue verification failed");
        $finish;
    end

endmodule
